@@ hdl/assert_macros.svh @@
// Assertion macros for the checker file of this project.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under an active-low synchronous reset.
`define CHK_ASSERT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("%m: assertion failed");

// Next-cycle implication under an active-low synchronous reset.
`define CHK_ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`endif

@@ hdl/tslpq_pkg.sv @@
// Types, constants and helpers for the three-level stable priority queue.
// No dependencies; used by tslpq_cell, the top level and the checker.
`timescale 1ns / 1ps

package tslpq_pkg;

    localparam int DEF_QUEUE_DEPTH = 16;
    localparam int TAG_W           = 16;
    localparam int LVL_W           = 2;
    localparam int CODE_W          = 3;
    localparam int STAT_W          = 2;
    localparam int S_TDATA_W       = 24;
    localparam int M_TDATA_W       = 24;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic {
        CMD_ENQ = 1'b0,
        CMD_DEQ = 1'b1
    } cmd_t;

    localparam logic [LVL_W-1:0] LVL_NONE = 2'd0;
    localparam logic [LVL_W-1:0] LVL_1    = 2'd1;
    localparam logic [LVL_W-1:0] LVL_2    = 2'd2;
    localparam logic [LVL_W-1:0] LVL_3    = 2'd3;

    // One stored entry
    typedef struct packed {
        logic [LVL_W-1:0] level;
        logic [TAG_W-1:0] tag;
    } entry_t;

    // Operation broadcast to every cell of the row
    typedef struct packed {
        logic   enq;
        logic   deq;
        entry_t ins;
    } cell_ctrl_t;

    // Class code to priority level
    function automatic logic [LVL_W-1:0] level_of(input logic [CODE_W-1:0] code);
        logic [LVL_W-1:0] lvl;
        case (code) inside
            3'd1, 3'd2: lvl = LVL_1;
            3'd3, 3'd4: lvl = LVL_2;
            default:    lvl = LVL_3;
        endcase
        return lvl;
    endfunction

endpackage

@@ hdl/tslpq_cell.sv @@
// One cell of the sorted queue row: holds one entry, shifts with its neighbors.
// Depends on tslpq_pkg.
`timescale 1ns / 1ps

module tslpq_cell #(
    parameter int IDX   = 0,
    parameter int CNT_W = 5
) (
    input  logic                  aclk,
    input  tslpq_pkg::cell_ctrl_t ctrl,
    input  logic [CNT_W-1:0]      count,
    input  logic                  prev_keep,  // upstream cell keeps its entry
    input  tslpq_pkg::entry_t     prev_ent,
    input  tslpq_pkg::entry_t     next_ent,
    output tslpq_pkg::entry_t     ent_out,
    output logic                  keep_out
);
    import tslpq_pkg::*;

    entry_t ent_reg;
    entry_t ent_next;
    logic   occupied;

    // Row is kept sorted by level, arrival order within a level
    assign occupied = (CNT_W'(IDX) < count);
    assign keep_out = occupied && (ent_reg.level <= ctrl.ins.level);
    assign ent_out  = ent_reg;

    // Insert: keep, take the new entry, or take the upstream one.
    // Remove: everything moves one cell toward the head.
    always_comb begin
        ent_next = ent_reg;
        if (ctrl.enq) begin
            if (keep_out) begin
                ent_next = ent_reg;
            end else if (prev_keep) begin
                ent_next = ctrl.ins;
            end else begin
                ent_next = prev_ent;
            end
        end else if (ctrl.deq) begin
            ent_next = next_ent;
        end
    end

    always_ff @(posedge aclk) begin
        ent_reg <= ent_next;
    end

endmodule

@@ hdl/three_level_stable_priority_queue.sv @@
// An accepted request is first held in the request register (pend_reg), then its result is
// registered into the output slot, where m_tvalid rises. A new request is not taken while
// one is pending in the request register, nor while a result is stalled by m_tready low.
// Reset: aresetn clears the occupancy count and both handshakes; cell contents
// are left as they are and read only below the occupancy count.
`timescale 1ns / 1ps

module three_level_stable_priority_queue #(
    parameter int QUEUE_DEPTH = tslpq_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [tslpq_pkg::S_TDATA_W-1:0] s_tdata,  // [2:0] class_code, [18:3] item_tag
    input  logic                            s_tuser,  // [0] cmd
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [tslpq_pkg::M_TDATA_W-1:0] m_tdata,  // [15:0] out_tag, [17:16] out_level
    output logic [tslpq_pkg::STAT_W-1:0]    m_tuser   // [1:0] status
);
    import tslpq_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic               pend_reg;
    cmd_t               cmd_reg;
    logic [LVL_W-1:0]   lvl_reg;
    logic [TAG_W-1:0]   tag_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               m_tvalid_reg;
    status_t            m_status_reg;
    status_t            m_status_next;
    entry_t             m_ent_reg;
    entry_t             m_ent_next;

    logic               s_acc;
    logic               full;
    logic               empty;
    cell_ctrl_t         ctrl;
    entry_t             ent  [QUEUE_DEPTH];
    logic               keep [QUEUE_DEPTH];

    // Input side: take a new request when none is pending and the output slot is free or draining
    assign s_tready = !pend_reg && (!m_tvalid_reg || m_tready);
    assign s_acc    = s_tvalid && s_tready;

    assign full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);

    // Operation for the cell row, gated by full and empty
    assign ctrl.enq = pend_reg && (cmd_reg == CMD_ENQ) && !full;
    assign ctrl.deq = pend_reg && (cmd_reg == CMD_DEQ) && !empty;
    assign ctrl.ins = '{level: lvl_reg, tag: tag_reg};

    // Row of cells, head at index 0
    for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
        logic   pk;
        entry_t pe;
        entry_t ne;
        if (i == 0) begin : g_head
            assign pk = 1'b1;
            assign pe = '0;
        end else begin : g_body
            assign pk = keep[i-1];
            assign pe = ent[i-1];
        end
        if (i == QUEUE_DEPTH - 1) begin : g_tail
            assign ne = '0;
        end else begin : g_inner
            assign ne = ent[i+1];
        end
        tslpq_cell #(
            .IDX   (i),
            .CNT_W (CNT_W)
        ) u_cell (
            .aclk      (aclk),
            .ctrl      (ctrl),
            .count     (count_reg),
            .prev_keep (pk),
            .prev_ent  (pe),
            .next_ent  (ne),
            .ent_out   (ent[i]),
            .keep_out  (keep[i])
        );
    end

    // Occupancy and result of the pending request
    always_comb begin
        count_next    = count_reg;
        m_status_next = ST_DONE;
        m_ent_next    = '{level: LVL_NONE, tag: '0};
        if (ctrl.enq) begin
            count_next = count_reg + CNT_W'(1);
        end
        if (ctrl.deq) begin
            count_next = count_reg - CNT_W'(1);
            m_ent_next = ent[0];
        end
        if (cmd_reg == CMD_ENQ && full) begin
            m_status_next = ST_FULL;
        end
        if (cmd_reg == CMD_DEQ && empty) begin
            m_status_next = ST_EMPTY;
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg     <= 1'b0;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            pend_reg  <= s_acc;
            count_reg <= count_next;
            if (pend_reg) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            cmd_reg <= cmd_t'(s_tuser);
            lvl_reg <= level_of(s_tdata[CODE_W-1:0]);
            tag_reg <= s_tdata[CODE_W +: TAG_W];
        end
        if (pend_reg) begin
            m_status_reg <= m_status_next;
            m_ent_reg    <= m_ent_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_W'({m_ent_reg.level, m_ent_reg.tag});
    assign m_tuser  = m_status_reg;

endmodule

@@ hdl/tslpq_checker.sv @@
// Port-level checker for three_level_stable_priority_queue, bound to the top.
// Depends on assert_macros.svh and tslpq_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tslpq_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic [1:0]  m_tuser
);
    import tslpq_pkg::*;

    // A stalled result holds
    `CHK_ASSERT_NEXT(a_m_hold, aclk, aresetn, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // Accepted transaction: no second accept next cycle, result the cycle after
    `CHK_ASSERT_NEXT(a_one_in_flight, aclk, aresetn, s_tvalid && s_tready,
        !s_tready ##1 m_tvalid)

    // Empty or full status carries no tag and no level
    `CHK_ASSERT(a_err_zero, aclk, aresetn, m_tvalid && m_tuser != ST_DONE,
        m_tdata == 24'd0 && (m_tuser == ST_EMPTY || m_tuser == ST_FULL))

    // A done result without a level is an enqueue and carries no tag
    `CHK_ASSERT(a_enq_no_tag, aclk, aresetn,
        m_tvalid && m_tuser == ST_DONE && m_tdata[17:16] == LVL_NONE,
        m_tdata[15:0] == 16'd0)

endmodule

bind three_level_stable_priority_queue tslpq_checker u_tslpq_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
